// ===== rtl/psath_pkg.sv =====
// Shared types and constants for the pressure sensor averager with trough hold.
// Used by the front, queue, back and top-level modules. No dependencies.
package psath_pkg;

  localparam int SAMPLE_W = 10;
  localparam int DATA_W   = 16;
  localparam int AGE_W    = 6;
  localparam int CFG_W    = 1;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] CMD_SAMPLE  = 2'd0;
  localparam logic [1:0] CMD_TICK    = 2'd1;
  localparam logic [1:0] CMD_DISPLAY = 2'd2;

  localparam logic [1:0] VIEW_ABS    = 2'd0;
  localparam logic [1:0] VIEW_REL    = 2'd1;
  localparam logic [1:0] VIEW_TROUGH = 2'd2;

  localparam logic [1:0] OP_SUM  = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_DISP = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_METRIC_ABS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_METRIC_REL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_METRIC_TRG = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_HOLD  = 2'd3;

  localparam logic [DATA_W-1:0] ZERO_OFFSET = 16'd6554;
  localparam logic [DATA_W-1:0] ATMOS_MBAR  = 16'd1013;
  localparam logic [DATA_W-1:0] METRIC_MAX  = 16'd9999;
  localparam logic [DATA_W-1:0] TROUGH_STEP = 16'd10;
  localparam logic [AGE_W-1:0]  SHORT_AGE   = 6'd20;
  localparam logic [AGE_W-1:0]  LONG_AGE    = 6'd40;

  // reciprocal multipliers: x/5 = (x*52429)>>18, x/370 = (x*45344)>>24,
  // 10x/69 = (x*2431481)>>24, all exact over 16-bit x
  localparam logic [15:0] DIV5_MUL   = 16'd52429;
  localparam logic [15:0] DIV370_MUL = 16'd45344;
  localparam int          PSI_MUL_W  = 22;
  localparam logic [PSI_MUL_W-1:0] PSI_MUL = 22'd2431481;
  localparam int          PSI_PROD_W = DATA_W + PSI_MUL_W;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [1:0]        op;
    logic [1:0]        view;
    logic [DATA_W-1:0] sum;
    logic [DATA_W-1:0] boost;
  } entry_t;

  typedef struct packed {
    logic metric_absolute;
    logic metric_relative;
    logic metric_trough;
    logic long_hold;
  } cfg_t;

endpackage

// ===== rtl/psath_front.sv =====
// Front end: accepts items, accumulates samples and classifies work for the back end.
// Depends on psath_pkg.
module psath_front #(
  parameter int SAMPLES_PER_SUM = 64,
  parameter int ADC_BITS = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic [1:0]                      command,
  input  logic [psath_pkg::SAMPLE_W-1:0]  sample,
  input  logic [1:0]                      view,
  input  logic [psath_pkg::DATA_W-1:0]    boost_mbar,
  output logic                            push,
  output psath_pkg::entry_t               push_entry
);

  localparam int CNT_W = $clog2(SAMPLES_PER_SUM + 1);

  logic [psath_pkg::DATA_W-1:0] running_sum;
  logic [psath_pkg::DATA_W-1:0] latched_sum;
  logic [CNT_W-1:0]             sample_count;
  logic [psath_pkg::DATA_W-1:0] sum_next;
  logic [CNT_W-1:0]             count_inc;
  logic                         complete;

  assign sum_next  = running_sum +
                     {{(psath_pkg::DATA_W-ADC_BITS){1'b0}}, sample[ADC_BITS-1:0]};
  assign count_inc = sample_count + 1'b1;
  assign complete  = count_inc >= CNT_W'(SAMPLES_PER_SUM);

  always_comb begin
    push            = 1'b0;
    push_entry.op   = psath_pkg::OP_SUM;
    push_entry.view = view;
    push_entry.sum  = latched_sum;
    push_entry.boost = boost_mbar;
    case (command)
      psath_pkg::CMD_SAMPLE: begin
        push           = accept && complete;
        push_entry.sum = sum_next;
      end
      psath_pkg::CMD_TICK: begin
        push          = accept;
        push_entry.op = psath_pkg::OP_TICK;
      end
      psath_pkg::CMD_DISPLAY: begin
        push          = accept && (view == psath_pkg::VIEW_ABS ||
                                   view == psath_pkg::VIEW_REL ||
                                   view == psath_pkg::VIEW_TROUGH);
        push_entry.op = psath_pkg::OP_DISP;
      end
      default: push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum  <= '0;
      latched_sum  <= '0;
      sample_count <= '0;
    end else if (accept && command == psath_pkg::CMD_SAMPLE) begin
      if (complete) begin
        running_sum  <= '0;
        latched_sum  <= sum_next;
        sample_count <= '0;
      end else begin
        running_sum  <= sum_next;
        sample_count <= count_inc;
      end
    end
  end

endmodule

// ===== rtl/psath_fifo.sv =====
// Short queue of classified work between the front and back ends.
// Depends on psath_pkg.
module psath_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  psath_pkg::entry_t push_entry,
  input  logic              pop,
  output logic              full,
  output logic              valid,
  output psath_pkg::entry_t head
);

  localparam int PTR_W = $clog2(psath_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(psath_pkg::QUEUE_DEPTH + 1);

  psath_pkg::entry_t mem [psath_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full    = count == CNT_W'(psath_pkg::QUEUE_DEPTH);
  assign valid   = count != '0;
  assign head    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/psath_back.sv =====
// Back end: mbar conversion, view selection, trough hold and unit scaling pipeline.
// Depends on psath_pkg.
module psath_back (
  input  logic                          clk,
  input  logic                          rst,
  input  psath_pkg::cfg_t               cfg,
  input  logic                          q_valid,
  input  psath_pkg::entry_t             q_head,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          kind,
  output logic [psath_pkg::DATA_W-1:0]  value,
  output logic                          differential,
  output logic                          flash
);

  localparam int DW = psath_pkg::DATA_W;
  localparam int AW = psath_pkg::AGE_W;
  localparam int PW = psath_pkg::PSI_PROD_W;

  logic adv;

  // stage 1
  logic          s1_valid;
  logic [1:0]    s1_op;
  logic [1:0]    s1_view;
  logic [DW-1:0] s1_sum;
  logic [DW-1:0] s1_boost;
  logic [31:0]   s1_prod5;
  logic [31:0]   s1_prod370;
  logic [DW-1:0] offset;

  // stage 2
  logic          s2_valid;
  logic          s2_kind;
  logic [DW-1:0] s2_v;
  logic          s2_cd;
  logic          s2_fl;
  logic          s2_metric;

  // stage 3
  logic          s3_valid;
  logic          s3_kind;
  logic [DW-1:0] s3_v;
  logic          s3_cd;
  logic          s3_fl;
  logic          s3_metric;
  logic [PW-1:0] s3_psi;

  // trough state
  logic [DW-1:0] trough_level;
  logic [AW-1:0] trough_age;
  logic [DW-1:0] trough_level_next;
  logic [AW-1:0] trough_age_next;

  logic [AW-1:0] age_limit;
  logic [DW-1:0] mbar;
  logic [DW-1:0] v_abs;
  logic [DW-1:0] v_rel;
  logic          lower;
  logic [DW-1:0] tl_eff;
  logic [AW-1:0] age_eff;
  logic          hold;
  logic [DW-1:0] disp_v;
  logic          disp_fl;
  logic          disp_metric;
  logic [DW-1:0] clamped;

  assign adv   = !out_valid || !out_stall;
  assign q_pop = adv && q_valid;

  assign offset = (q_head.sum > psath_pkg::ZERO_OFFSET) ?
                  q_head.sum - psath_pkg::ZERO_OFFSET : '0;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op      <= q_head.op;
      s1_view    <= q_head.view;
      s1_sum     <= q_head.sum;
      s1_boost   <= q_head.boost;
      s1_prod5   <= offset * psath_pkg::DIV5_MUL;
      s1_prod370 <= offset * psath_pkg::DIV370_MUL;
    end
  end

  assign age_limit = cfg.long_hold ? psath_pkg::LONG_AGE : psath_pkg::SHORT_AGE;
  assign mbar      = DW'(s1_prod5[31:18]) + psath_pkg::ATMOS_MBAR - DW'(s1_prod370[31:24]);
  assign v_abs     = mbar - psath_pkg::ATMOS_MBAR;
  assign v_rel     = mbar - s1_boost;
  assign lower     = v_rel < trough_level;
  assign tl_eff    = lower ? v_rel : trough_level;
  assign age_eff   = lower ? '0 : trough_age;
  assign hold      = age_eff < age_limit;

  always_comb begin
    disp_v      = v_rel;
    disp_fl     = 1'b0;
    disp_metric = cfg.metric_relative;
    trough_level_next = trough_level;
    trough_age_next   = trough_age;
    case (s1_op)
      psath_pkg::OP_TICK: begin
        if (trough_age < age_limit) trough_age_next = trough_age + 1'b1;
      end
      psath_pkg::OP_DISP: begin
        case (s1_view)
          psath_pkg::VIEW_ABS: begin
            disp_v      = v_abs;
            disp_metric = cfg.metric_absolute;
          end
          psath_pkg::VIEW_TROUGH: begin
            disp_metric     = cfg.metric_trough;
            trough_age_next = age_eff;
            if (hold) begin
              disp_fl           = 1'b1;
              disp_v            = tl_eff;
              trough_level_next = tl_eff;
            end else begin
              trough_level_next = v_rel - psath_pkg::TROUGH_STEP;
            end
          end
          default: disp_metric = cfg.metric_relative;
        endcase
      end
      default: disp_v = v_rel;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_kind   <= s1_op == psath_pkg::OP_DISP;
      s2_v      <= (s1_op == psath_pkg::OP_DISP) ? disp_v : s1_sum;
      s2_cd     <= s1_op == psath_pkg::OP_DISP && s1_view != psath_pkg::VIEW_ABS;
      s2_fl     <= s1_op == psath_pkg::OP_DISP && disp_fl;
      s2_metric <= disp_metric;
      s3_kind   <= s2_kind;
      s3_v      <= s2_v;
      s3_cd     <= s2_cd;
      s3_fl     <= s2_fl;
      s3_metric <= s2_metric;
      s3_psi    <= {{(PW-DW){1'b0}}, s2_v} * {{(PW-psath_pkg::PSI_MUL_W){1'b0}}, psath_pkg::PSI_MUL};
    end
  end

  assign clamped = (s3_v > psath_pkg::METRIC_MAX) ? psath_pkg::METRIC_MAX : s3_v;

  always_ff @(posedge clk) begin
    if (adv) begin
      kind         <= s3_kind;
      differential <= s3_cd;
      flash        <= s3_fl;
      if (!s3_kind) begin
        value <= s3_v;
      end else if (s3_metric) begin
        value <= clamped;
      end else begin
        value <= DW'(s3_psi[PW-1:24]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      out_valid    <= 1'b0;
      trough_level <= '0;
      trough_age   <= '0;
    end else if (adv) begin
      s1_valid  <= q_valid;
      s2_valid  <= s1_valid && s1_op != psath_pkg::OP_TICK;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
      if (s1_valid) begin
        trough_level <= trough_level_next;
        trough_age   <= trough_age_next;
      end
    end
  end

endmodule

// ===== rtl/pressure_sensor_averager_trough_hold_top.sv =====
// Top level of the pressure sensor averager with trough hold: config registers,
// front end, work queue and back-end pipeline. Depends on psath_pkg and submodules.
//
// Takes one item per clock while the queue is not full and delivers one result
// per clock while the output is not stalled. A result passes through the
// four-entry work queue, then three back-end stages (reciprocal multiplies for the
// mbar conversion, view and trough update, psi scaling multiply) into the output
// register. Ticks and samples that do not complete a sum produce no result. Input
// stall rises only once the queue fills behind a stalled output.
module pressure_sensor_averager_trough_hold_top #(
  parameter int SAMPLES_PER_SUM = 64,
  parameter int ADC_BITS = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        command,
  input  logic [psath_pkg::SAMPLE_W-1:0]    sample,
  input  logic [1:0]                        view,
  input  logic [psath_pkg::DATA_W-1:0]      boost_mbar,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              kind,
  output logic [psath_pkg::DATA_W-1:0]      value,
  output logic                              differential,
  output logic                              flash,
  input  logic                              cfg_write,
  input  logic [psath_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psath_pkg::CFG_W-1:0]       cfg_data
);

  psath_pkg::cfg_t   cfg;
  psath_pkg::entry_t push_entry;
  psath_pkg::entry_t q_head;
  logic              accept;
  logic              push;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        psath_pkg::REG_METRIC_ABS: cfg.metric_absolute <= cfg_data[0];
        psath_pkg::REG_METRIC_REL: cfg.metric_relative <= cfg_data[0];
        psath_pkg::REG_METRIC_TRG: cfg.metric_trough   <= cfg_data[0];
        psath_pkg::REG_LONG_HOLD:  cfg.long_hold       <= cfg_data[0];
        default: cfg <= cfg;
      endcase
    end
  end

  psath_front #(
    .SAMPLES_PER_SUM(SAMPLES_PER_SUM),
    .ADC_BITS(ADC_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .command(command),
    .sample(sample),
    .view(view),
    .boost_mbar(boost_mbar),
    .push(push),
    .push_entry(push_entry)
  );

  psath_fifo u_fifo (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_entry(push_entry),
    .pop(q_pop),
    .full(q_full),
    .valid(q_valid),
    .head(q_head)
  );

  psath_back u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .q_valid(q_valid),
    .q_head(q_head),
    .q_pop(q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .value(value),
    .differential(differential),
    .flash(flash)
  );

  a_sum_plain: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kind |-> !differential && !flash)
    else $error("sum result carries display flags");

  a_flash_rel: assert property (@(posedge clk) disable iff (rst)
    out_valid && flash |-> differential)
    else $error("trough flash outside relative view");

  a_disp_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind |-> value <= psath_pkg::METRIC_MAX)
    else $error("display value out of range");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result present after reset");

endmodule
